// ===== sv/fpvm_pkg.sv =====
// Shared types and constants for the phase voltage modulator.
// No dependencies; the front, back and top-level files refer to this package by scoped names.
package fpvm_pkg;

    localparam int PH_W      = 56;
    localparam int MID_DEPTH = 8;
    localparam int OUT_DEPTH = 32;

    localparam logic [15:0] SQRT3_FIX = 16'd56756;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic MODE_SINE  = 1'b0;
    localparam logic MODE_SVPWM = 1'b1;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_LIMIT  = 3'd1,
        REG_SUPPLY = 3'd2,
        REG_OFFSET = 3'd3,
        REG_PERIOD = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        SEL_DIV  = 2'd0,
        SEL_ZERO = 2'd1,
        SEL_FULL = 2'd2
    } cmp_sel_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] limit;
        logic [15:0] supply;
        logic [15:0] offset;
        logic [15:0] period;
    } cfg_t;

    typedef struct packed {
        logic signed [PH_W-1:0] ua;
        logic signed [PH_W-1:0] ub;
        logic signed [PH_W-1:0] uc;
    } phase_t;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
    } cmp_t;

endpackage

// ===== sv/fpvm_intf.sv =====
// Valid/ready channel interfaces for the voltage vector input and compare output.
// No dependencies.
interface fpvm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] volt_q;
    logic signed [15:0] volt_d;
    logic        [15:0] elec_angle;
    modport source (output valid, volt_q, volt_d, elec_angle, input ready);
    modport sink (input valid, volt_q, volt_d, elec_angle, output ready);
endinterface

interface fpvm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;
    modport source (output valid, compare_a, compare_b, compare_c, input ready);
    modport sink (input valid, compare_a, compare_b, compare_c, output ready);
endinterface

// ===== sv/fpvm_fifo.sv =====
// Small register FIFO used for the middle queue and the output queue.
// No package dependency; overflow is prevented by the caller's credit count.
module fpvm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = mem_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
endmodule

// ===== sv/fpvm_front.sv =====
// Front section: accepts voltage vectors, does table lookups, inverse Park/Clarke
// or sector timing, and pushes phase voltages (Q40) into the middle queue. Uses fpvm_pkg.
module fpvm_front #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fpvm_pkg::cfg_t     cfg,
    fpvm_in_if.sink            vec,
    input  logic               drain,
    output logic               push,
    output fpvm_pkg::phase_t   push_data
);
    localparam int B   = SINE_TABLE_BITS;
    localparam int QTR = 1 << (B - 2);
    localparam int CW  = $clog2(fpvm_pkg::MID_DEPTH + 1);
    localparam int W   = fpvm_pkg::PH_W;

    typedef logic [16:0] tab_t [0:QTR];

    function automatic tab_t build_tab();
        tab_t        t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] tt;
        logic [63:0] s;
        for (int j = 0; j <= QTR; j++)
        begin
            x  = (64'(j) * fpvm_pkg::HALF_PI_Q30) >> (B - 2);
            x2 = (x * x) >> 30;
            tt = fpvm_pkg::Q30_ONE - x2 / 64'd72;
            tt = fpvm_pkg::Q30_ONE - ((x2 * tt) >> 30) / 64'd42;
            tt = fpvm_pkg::Q30_ONE - ((x2 * tt) >> 30) / 64'd20;
            tt = fpvm_pkg::Q30_ONE - ((x2 * tt) >> 30) / 64'd6;
            s  = (x * tt) >> 30;
            t[j] = 17'((s + 64'd16384) >> 15);
        end
        return t;
    endfunction

    localparam tab_t TAB = build_tab();

    function automatic logic signed [17:0] sine_of(input logic [15:0] a);
        logic [B-1:0] k;
        logic [1:0]   quad;
        logic [B-2:0] j;
        logic [B-2:0] jm;
        logic [16:0]  mag;
        k    = a[15 -: B];
        quad = k[B-1 -: 2];
        j    = {1'b0, k[B-3:0]};
        jm   = (B-1)'(QTR) - j;
        mag  = quad[0] ? TAB[jm] : TAB[j];
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function automatic logic [B-2:0] sector_idx(input logic [16:0] n);
        logic [16:0] x;
        logic [31:0] m;
        x = n >> (17 - B);
        m = 32'(x) * 32'd43691;
        return m[17 +: (B - 1)];
    endfunction

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          acc;
    logic [5:0]    v_reg, v_next;

    // stage 0
    logic        [15:0] ang0_reg;
    logic signed [15:0] uq0_reg, ud0_reg;
    logic        [16:0] auq0_reg;
    logic        [2:0]  sec0_reg;
    logic        [15:0] r0_reg;
    // stage 1
    logic signed [17:0] sa1_reg, ca1_reg;
    logic        [16:0] ta1_reg, tb1_reg;
    logic signed [15:0] uq1_reg, ud1_reg;
    logic        [16:0] auq1_reg;
    logic        [2:0]  sec1_reg;
    // stage 2
    logic signed [33:0] pcd2_reg, psq2_reg, psd2_reg, pcq2_reg;
    logic        [32:0] ma2_reg, mb2_reg;
    logic        [16:0] auq2_reg;
    logic        [2:0]  sec2_reg;
    // stage 3
    logic signed [34:0] alpha3_reg, beta3_reg;
    logic        [51:0] a3_reg, b3_reg;
    logic        [2:0]  sec3_reg;
    // stage 4
    logic signed [34:0] alpha4_reg;
    logic signed [52:0] bt4_reg;
    fpvm_pkg::phase_t   sv4_reg;
    // stage 5
    fpvm_pkg::phase_t   ph5_reg, ph5_next;

    logic        [15:0] ang_sv;
    logic        [18:0] p6;
    logic signed [W-1:0] lim40, sa, sb, sh, half;
    fpvm_pkg::phase_t   sv_next;

    assign acc       = vec.valid && vec.ready;
    assign vec.ready = (cnt_reg < CW'(fpvm_pkg::MID_DEPTH));
    assign push      = v_reg[5];
    assign push_data = ph5_reg;

    always_comb
    begin
        cnt_next = cnt_reg + CW'(acc) - CW'(drain);
        v_next   = {v_reg[4:0], acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            v_reg   <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            v_reg   <= v_next;
        end
    end

    always_comb
    begin
        ang_sv = vec.elec_angle + cfg.offset + 16'd16384
               + (vec.volt_q[15] ? 16'd32768 : 16'd0);
        p6     = 19'(ang_sv) * 19'd6;
    end

    always_comb
    begin
        lim40 = $signed({8'd0, cfg.limit, 32'd0});
        sa    = $signed(W'(a3_reg));
        sb    = $signed(W'(b3_reg));
        sh    = (lim40 - sa - sb) >>> 1;
        sv_next = '{ua: sh, ub: sh, uc: sh};
        unique case (sec3_reg)
            3'd0:    sv_next = '{ua: sa + sb + sh, ub: sb + sh, uc: sh};
            3'd1:    sv_next = '{ua: sa + sh, ub: sa + sb + sh, uc: sh};
            3'd2:    sv_next = '{ua: sh, ub: sa + sb + sh, uc: sb + sh};
            3'd3:    sv_next = '{ua: sh, ub: sa + sh, uc: sa + sb + sh};
            3'd4:    sv_next = '{ua: sb + sh, ub: sh, uc: sa + sb + sh};
            default: sv_next = '{ua: sa + sb + sh, ub: sh, uc: sa + sh};
        endcase
    end

    always_comb
    begin
        half = $signed(W'(cfg.limit)) <<< 31;
        if (cfg.mode == fpvm_pkg::MODE_SINE)
        begin
            ph5_next.ua = (W'(alpha4_reg) <<< 17) + half;
            ph5_next.ub = -(W'(alpha4_reg) <<< 16) + W'(bt4_reg) + half;
            ph5_next.uc = -(W'(alpha4_reg) <<< 16) - W'(bt4_reg) + half;
        end
        else
        begin
            ph5_next = sv4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ang0_reg <= vec.elec_angle;
        uq0_reg  <= vec.volt_q;
        ud0_reg  <= vec.volt_d;
        auq0_reg <= vec.volt_q[15] ? 17'(-$signed(17'(vec.volt_q)))
                                   : 17'(vec.volt_q);
        sec0_reg <= p6[18:16];
        r0_reg   <= p6[15:0];

        sa1_reg  <= sine_of(ang0_reg);
        ca1_reg  <= sine_of(ang0_reg + 16'd16384);
        ta1_reg  <= TAB[sector_idx(17'h10000 - 17'(r0_reg))];
        tb1_reg  <= TAB[sector_idx(17'(r0_reg))];
        uq1_reg  <= uq0_reg;
        ud1_reg  <= ud0_reg;
        auq1_reg <= auq0_reg;
        sec1_reg <= sec0_reg;

        pcd2_reg <= 34'(ca1_reg) * 34'(ud1_reg);
        psq2_reg <= 34'(sa1_reg) * 34'(uq1_reg);
        psd2_reg <= 34'(sa1_reg) * 34'(ud1_reg);
        pcq2_reg <= 34'(ca1_reg) * 34'(uq1_reg);
        ma2_reg  <= 33'(ta1_reg) * 33'(fpvm_pkg::SQRT3_FIX);
        mb2_reg  <= 33'(tb1_reg) * 33'(fpvm_pkg::SQRT3_FIX);
        auq2_reg <= auq1_reg;
        sec2_reg <= sec1_reg;

        alpha3_reg <= 35'(pcd2_reg) - 35'(psq2_reg);
        beta3_reg  <= 35'(psd2_reg) + 35'(pcq2_reg);
        a3_reg     <= (52'(ma2_reg) * 52'(auq2_reg)) << 2;
        b3_reg     <= (52'(mb2_reg) * 52'(auq2_reg)) << 2;
        sec3_reg   <= sec2_reg;

        alpha4_reg <= alpha3_reg;
        bt4_reg    <= 53'(beta3_reg) * 53'sd113512;
        sv4_reg    <= sv_next;

        ph5_reg    <= ph5_next;
    end
endmodule

// ===== sv/fpvm_back.sv =====
// Back section: clamps phase voltages, scales by the timer period and divides by
// the supply voltage one quotient bit per stage. Uses fpvm_pkg.
module fpvm_back (
    input  logic             clk,
    input  logic             rst_n,
    input  fpvm_pkg::cfg_t   cfg,
    input  logic             in_valid,
    input  fpvm_pkg::phase_t in_data,
    output logic             in_pop,
    input  logic             drain,
    output logic             push,
    output fpvm_pkg::cmp_t   push_data
);
    localparam int CW = $clog2(fpvm_pkg::OUT_DEPTH + 1);
    localparam int W  = fpvm_pkg::PH_W;
    localparam int NS = 16;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    vb_reg, vb_next;
    logic [NS:1]   vd_reg, vd_next;

    logic signed [W-1:0] u_in [3];
    logic signed [W-1:0] lim40;

    logic [47:0]        uu0_reg [3];
    fpvm_pkg::cmp_sel_t sel0_reg [3];
    logic [39:0]        ph1_reg [3], pl1_reg [3];
    fpvm_pkg::cmp_sel_t sel1_reg [3];

    logic [31:0]        rem_reg [0:NS][3], rem_next [1:NS][3];
    logic [15:0]        q_reg [0:NS][3], q_next [1:NS][3];
    fpvm_pkg::cmp_sel_t seld_reg [0:NS][3];

    logic [63:0] n2 [3];
    logic [15:0] res [3];

    assign in_pop = in_valid && (cnt_reg < CW'(fpvm_pkg::OUT_DEPTH));
    assign push   = vd_reg[NS];

    assign u_in[0] = in_data.ua;
    assign u_in[1] = in_data.ub;
    assign u_in[2] = in_data.uc;
    assign lim40   = $signed({8'd0, cfg.limit, 32'd0});

    always_comb
    begin
        cnt_next = cnt_reg + CW'(in_pop) - CW'(drain);
        vb_next  = {vb_reg[1:0], in_pop};
        vd_next  = {vd_reg[NS-1:1], vb_reg[2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            vb_reg  <= '0;
            vd_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            vb_reg  <= vb_next;
            vd_reg  <= vd_next;
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            n2[l] = (64'(ph1_reg[l]) << 24) + 64'(pl1_reg[l]);
        end
        for (int s = 1; s <= NS; s++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                rem_next[s][l] = rem_reg[s-1][l];
                q_next[s][l]   = q_reg[s-1][l];
                if (rem_reg[s-1][l] >= (32'(cfg.supply) << (NS - s)))
                begin
                    rem_next[s][l] = rem_reg[s-1][l] - (32'(cfg.supply) << (NS - s));
                    q_next[s][l][NS - s] = 1'b1;
                end
            end
        end
        for (int l = 0; l < 3; l++)
        begin
            unique case (seld_reg[NS][l])
                fpvm_pkg::SEL_ZERO: res[l] = '0;
                fpvm_pkg::SEL_FULL: res[l] = cfg.period;
                default:
                    res[l] = (q_reg[NS][l] > cfg.period) ? cfg.period : q_reg[NS][l];
            endcase
        end
    end

    assign push_data = '{a: res[0], b: res[1], c: res[2]};

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (u_in[l] < 0)
            begin
                uu0_reg[l] <= '0;
            end
            else if (u_in[l] > lim40)
            begin
                uu0_reg[l] <= lim40[47:0];
            end
            else
            begin
                uu0_reg[l] <= u_in[l][47:0];
            end
            priority if (cfg.supply == 16'd0)
            begin
                sel0_reg[l] <= fpvm_pkg::SEL_ZERO;
            end
            else if ((u_in[l] >= 0) && ((u_in[l] > lim40 ? cfg.limit : u_in[l][47:32])
                                        >= cfg.supply))
            begin
                sel0_reg[l] <= fpvm_pkg::SEL_FULL;
            end
            else
            begin
                sel0_reg[l] <= fpvm_pkg::SEL_DIV;
            end

            ph1_reg[l]  <= 40'(uu0_reg[l][47:24]) * 40'(cfg.period);
            pl1_reg[l]  <= 40'(uu0_reg[l][23:0]) * 40'(cfg.period);
            sel1_reg[l] <= sel0_reg[l];

            rem_reg[0][l]  <= n2[l][63:32];
            q_reg[0][l]    <= '0;
            seld_reg[0][l] <= sel1_reg[l];
            for (int s = 1; s <= NS; s++)
            begin
                rem_reg[s][l]  <= rem_next[s][l];
                q_reg[s][l]    <= q_next[s][l];
                seld_reg[s][l] <= seld_reg[s-1][l];
            end
        end
    end
endmodule

// ===== sv/foc_phase_voltage_modulator.sv =====
// Field-oriented phase voltage modulator, top level.
// Depends on fpvm_pkg, fpvm_intf, fpvm_fifo, fpvm_front and fpvm_back.
//
// vec carries a q/d voltage pair (signed Q8.8) and an electrical angle; cmp
// returns the three timer compare counts for that vector. Both are valid/ready
// channels; one beat in gives exactly one beat out, in order.
// cfg_we/cfg_index/cfg_data write the mode, voltage limit, supply voltage,
// zero offset and timer period; write only while no beat is in flight.
// Throughput is one beat per cycle while cmp takes every beat. An accepted input
// beat passes through six front stages, the middle queue, three clamp/scale
// stages, a sixteen-stage restoring divider (one quotient bit per stage) that
// divides by the supply voltage, and the output queue.
// A stalled cmp fills the 32-entry output queue, then the middle queue, and
// only then drops vec.ready; beats in flight are never lost.
// Reset empties both queues and loads the register defaults (sine mode, limit
// and supply 12 V, zero offset, period 4199).
module foc_phase_voltage_modulator #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    fpvm_in_if.sink     vec,
    fpvm_out_if.source  cmp
);
    fpvm_pkg::cfg_t   cfg_reg, cfg_next;
    logic             mid_push, mid_pop, mid_ne;
    fpvm_pkg::phase_t mid_in, mid_out;
    logic             out_push, out_pop;
    fpvm_pkg::cmp_t   out_in, out_head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                fpvm_pkg::REG_MODE:   cfg_next.mode   = cfg_data[0];
                fpvm_pkg::REG_LIMIT:  cfg_next.limit  = cfg_data;
                fpvm_pkg::REG_SUPPLY: cfg_next.supply = cfg_data;
                fpvm_pkg::REG_OFFSET: cfg_next.offset = cfg_data;
                fpvm_pkg::REG_PERIOD: cfg_next.period = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{mode: fpvm_pkg::MODE_SINE, limit: 16'd3072, supply: 16'd3072,
                         offset: 16'd0, period: 16'd4199};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fpvm_front #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .vec       (vec),
        .drain     (mid_pop),
        .push      (mid_push),
        .push_data (mid_in)
    );

    fpvm_fifo #(
        .WIDTH ($bits(fpvm_pkg::phase_t)),
        .DEPTH (fpvm_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_data (mid_in),
        .pop       (mid_pop),
        .pop_data  (mid_out),
        .not_empty (mid_ne)
    );

    fpvm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (mid_ne),
        .in_data   (mid_out),
        .in_pop    (mid_pop),
        .drain     (out_pop),
        .push      (out_push),
        .push_data (out_in)
    );

    fpvm_fifo #(
        .WIDTH ($bits(fpvm_pkg::cmp_t)),
        .DEPTH (fpvm_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_in),
        .pop       (out_pop),
        .pop_data  (out_head),
        .not_empty (cmp.valid)
    );

    assign out_pop       = cmp.valid && cmp.ready;
    assign cmp.compare_a = out_head.a;
    assign cmp.compare_b = out_head.b;
    assign cmp.compare_c = out_head.c;
endmodule
